// ===== hw/rtl/grid_walk_counter_core_defines.svh =====
// Assertion helpers used by gwc_back.
`ifndef GRID_WALK_COUNTER_CORE_DEFINES_SVH
`define GRID_WALK_COUNTER_CORE_DEFINES_SVH

// Check a property on every rising aclk edge outside of reset.
`define GWC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same, with an implication from a trigger to a next-cycle consequence.
`define GWC_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gwc_pkg.sv =====
`default_nettype none
package gwc_pkg;
    localparam int MAX_ROWS = 4;
    localparam int MAX_COLS = 4;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;
    localparam int CELL_W   = $clog2(CELLS);
    localparam int CNT_W    = $clog2(CELLS + 1);
    localparam int DIM_W    = 3;
    localparam int TOT_W    = 2 * DIM_W;
    localparam int LEN_W    = 16;
    localparam int COUNT_W  = 64;
    localparam int CIDX_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RIDX_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    typedef enum logic [1:0] {
        KIND_OPEN   = 2'd0,
        KIND_WALL   = 2'd1,
        KIND_START  = 2'd2,
        KIND_FINISH = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_ROWS   = 2'd0,
        REG_COLS   = 2'd1,
        REG_LENGTH = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic [CELLS-1:0]  wall;
        logic [CELL_W-1:0] start;
        logic [CELL_W-1:0] finish;
        logic [DIM_W-1:0]  rows;
        logic [DIM_W-1:0]  cols;
        logic [LEN_W-1:0]  length;
    } job_t;

    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0) r = DIM_W'(1);
        else if (v > hi) r = hi;
        else r = v;
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/gwc_front.sv =====
`default_nettype none
module gwc_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cell_fire,
    input  wire gwc_pkg::kind_t               cell_kind,
    input  wire logic [gwc_pkg::DIM_W-1:0]    rows_eff,
    input  wire logic [gwc_pkg::DIM_W-1:0]    cols_eff,
    input  wire logic [gwc_pkg::LEN_W-1:0]    walk_length,
    output logic                              job_push,
    output gwc_pkg::job_t                     job_data
);
    logic [gwc_pkg::CELL_W-1:0] cnt_reg, cnt_next;
    logic [gwc_pkg::CELL_W-1:0] start_reg, start_next;
    logic [gwc_pkg::CELL_W-1:0] finish_reg, finish_next;
    logic [gwc_pkg::CELLS-1:0]  wall_reg, wall_next;
    logic [gwc_pkg::CNT_W-1:0]  cnt_inc;
    logic [gwc_pkg::TOT_W-1:0]  total;
    logic                       grid_done;

    assign total     = gwc_pkg::TOT_W'(rows_eff) * gwc_pkg::TOT_W'(cols_eff);
    assign cnt_inc   = gwc_pkg::CNT_W'(cnt_reg) + gwc_pkg::CNT_W'(1);
    assign grid_done = gwc_pkg::TOT_W'(cnt_inc) >= total;

    always_comb begin
        wall_next   = wall_reg;
        start_next  = start_reg;
        finish_next = finish_reg;
        wall_next[cnt_reg] = (cell_kind == gwc_pkg::KIND_WALL);
        if (cell_kind == gwc_pkg::KIND_START) start_next = cnt_reg;
        else if (cell_kind == gwc_pkg::KIND_FINISH) finish_next = cnt_reg;
        cnt_next = cnt_inc[gwc_pkg::CELL_W-1:0];
    end

    assign job_push        = cell_fire && grid_done;
    assign job_data.wall   = wall_next;
    assign job_data.start  = start_next;
    assign job_data.finish = finish_next;
    assign job_data.rows   = rows_eff;
    assign job_data.cols   = cols_eff;
    assign job_data.length = walk_length;

    always_ff @(posedge aclk) begin
        if (cell_fire) wall_reg <= wall_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            start_reg  <= '0;
            finish_reg <= '0;
        end else if (cell_fire) begin
            if (grid_done) begin
                cnt_reg    <= '0;
                start_reg  <= '0;
                finish_reg <= '0;
            end else begin
                cnt_reg    <= cnt_next;
                start_reg  <= start_next;
                finish_reg <= finish_next;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/gwc_queue.sv =====
`default_nettype none
module gwc_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire gwc_pkg::job_t push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output gwc_pkg::job_t      pop_data
);
    gwc_pkg::job_t slot_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) slot_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push && !full) wr_reg <= ~wr_reg;
            if (pop && not_empty) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/gwc_back.sv =====
`default_nettype none
`include "grid_walk_counter_core_defines.svh"
module gwc_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          job_valid,
    input  wire gwc_pkg::job_t                 job_data,
    output logic                               job_pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [gwc_pkg::COUNT_W-1:0]        out_count
);
    localparam int N = gwc_pkg::CELLS;

    gwc_pkg::back_state_t state_reg, state_next;
    gwc_pkg::job_t        job_reg;
    logic [gwc_pkg::LEN_W-1:0]   rem_reg;
    logic [gwc_pkg::COUNT_W-1:0] vec_reg [N];
    logic [gwc_pkg::COUNT_W-1:0] vec_next [N];
    logic [gwc_pkg::COUNT_W-1:0] count_reg;
    logic [gwc_pkg::TOT_W-1:0]   dim;
    logic [N-1:0]                open_vec;
    logic                        ends_ok;

    assign dim = gwc_pkg::TOT_W'(job_reg.rows) * gwc_pkg::TOT_W'(job_reg.cols);
    assign ends_ok = (gwc_pkg::TOT_W'(job_reg.start) < dim)
                  && (gwc_pkg::TOT_W'(job_reg.finish) < dim);

    genvar j, cc;
    generate
        for (j = 0; j < N; j++) begin : g_lane
            logic [gwc_pkg::CELL_W-1:0]  col_tab [gwc_pkg::MAX_COLS];
            logic [gwc_pkg::CELL_W-1:0]  row_tab [gwc_pkg::MAX_COLS];
            logic [gwc_pkg::COUNT_W-1:0] up_tab  [gwc_pkg::MAX_COLS];
            logic [gwc_pkg::COUNT_W-1:0] dn_tab  [gwc_pkg::MAX_COLS];
            logic [gwc_pkg::CELL_W-1:0]  col, row;
            logic [gwc_pkg::COUNT_W-1:0] lf, rt, up, dn;
            logic [gwc_pkg::CIDX_W-1:0]  csel;

            assign open_vec[j] = !job_reg.wall[j] && (gwc_pkg::TOT_W'(j) < dim);

            for (cc = 1; cc <= gwc_pkg::MAX_COLS; cc++) begin : g_cols
                localparam int COLC = j % cc;
                localparam int ROWC = j / cc;
                assign col_tab[cc-1] = gwc_pkg::CELL_W'(COLC);
                assign row_tab[cc-1] = gwc_pkg::CELL_W'(ROWC);
                if (j >= cc) begin : g_up
                    assign up_tab[cc-1] = open_vec[j-cc] ? vec_reg[j-cc] : '0;
                end else begin : g_no_up
                    assign up_tab[cc-1] = '0;
                end
                if (j + cc < N) begin : g_dn
                    assign dn_tab[cc-1] = open_vec[j+cc] ? vec_reg[j+cc] : '0;
                end else begin : g_no_dn
                    assign dn_tab[cc-1] = '0;
                end
            end

            assign csel = gwc_pkg::CIDX_W'(job_reg.cols - gwc_pkg::DIM_W'(1));
            assign col  = col_tab[csel];
            assign row  = row_tab[csel];

            if (j > 0) begin : g_lf
                assign lf = (col != '0 && open_vec[j-1]) ? vec_reg[j-1] : '0;
            end else begin : g_no_lf
                assign lf = '0;
            end
            if (j + 1 < N) begin : g_rt
                assign rt = ((gwc_pkg::DIM_W'(col) + gwc_pkg::DIM_W'(1)) < job_reg.cols
                             && open_vec[j+1]) ? vec_reg[j+1] : '0;
            end else begin : g_no_rt
                assign rt = '0;
            end
            assign up = (row != '0) ? up_tab[csel] : '0;
            assign dn = ((gwc_pkg::DIM_W'(row) + gwc_pkg::DIM_W'(1)) < job_reg.rows)
                        ? dn_tab[csel] : '0;

            assign vec_next[j] = open_vec[j] ? ((lf + rt) + (up + dn)) : '0;
        end
    endgenerate

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gwc_pkg::ST_IDLE: if (job_valid) state_next = gwc_pkg::ST_RUN;
            gwc_pkg::ST_RUN:  if (rem_reg == '0) state_next = gwc_pkg::ST_OUT;
            gwc_pkg::ST_OUT:  if (out_ready) state_next = gwc_pkg::ST_IDLE;
            default:          state_next = gwc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        job_pop   = (state_reg == gwc_pkg::ST_IDLE) && job_valid;
        out_valid = (state_reg == gwc_pkg::ST_OUT);
    end

    assign out_count = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= gwc_pkg::ST_IDLE;
        else state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            job_reg <= job_data;
            rem_reg <= job_data.length;
            for (int i = 0; i < N; i++)
                vec_reg[i] <= (gwc_pkg::CELL_W'(i) == job_data.start)
                              ? gwc_pkg::COUNT_W'(1) : '0;
        end else if (state_reg == gwc_pkg::ST_RUN) begin
            if (rem_reg == '0) begin
                count_reg <= ends_ok ? vec_reg[job_reg.finish] : '0;
            end else begin
                rem_reg <= rem_reg - gwc_pkg::LEN_W'(1);
                for (int i = 0; i < N; i++) vec_reg[i] <= vec_next[i];
            end
        end
    end

    `GWC_ASSERT(a_pop_idle, !job_pop || state_reg == gwc_pkg::ST_IDLE, "pop outside idle")
    `GWC_ASSERT_NEXT(a_run_done, state_reg == gwc_pkg::ST_RUN && rem_reg == '0,
        state_reg == gwc_pkg::ST_OUT, "run did not finish")
    `GWC_ASSERT_NEXT(a_rem_dec, state_reg == gwc_pkg::ST_RUN && rem_reg != '0,
        rem_reg == $past(rem_reg) - gwc_pkg::LEN_W'(1), "step counter slipped")
endmodule
`default_nettype wire

// ===== hw/rtl/grid_walk_counter_core.sv =====
// grid_walk_counter_core: counts start-to-finish walks of an exact length on a small grid.
// Input channel s_*: one beat per grid cell in row-major order, s_tdata[1:0] holds the
//   cell kind (open, wall, start, finish). The beat that completes grid_rows*grid_cols
//   cells closes the grid and queues it for counting.
// Result channel m_*: one beat per grid, m_tdata carries the 64-bit walk count.
// Config channel cfg_*: index 0 rows, 1 cols, 2 walk length; always ready. Write only
//   while the block is idle.
// Throughput: cells load one per cycle while s_tready is high. For each grid the counting
//   engine takes the grid, makes one vector step per walk step across 16 cell lanes,
//   latches the count and holds it on the result channel until accepted; it takes the
//   next grid only after the result is accepted.
// A two-entry grid queue sits between loader and engine; the loader keeps taking cells
//   while the engine counts, and drops s_tready only when both entries are full.
// When the receiver stalls, the count holds on m_tdata and the engine waits; queued
//   grids and loading continue until the queue fills.
// Reset (aresetn low, synchronous): config returns to 4x4 grid with walk length 1,
//   the cell counter and markers clear, the queue empties and no result is pending.
`default_nettype none
module grid_walk_counter_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [1:0] cell_kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,    // [63:0] walk_count
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    logic [gwc_pkg::DIM_W-1:0] rows_reg, cols_reg;
    logic [gwc_pkg::LEN_W-1:0] length_reg;
    logic [gwc_pkg::DIM_W-1:0] rows_eff, cols_eff;
    logic                      cell_fire, q_full, q_valid, push, pop;
    gwc_pkg::job_t             push_job, pop_job;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign cell_fire = s_tvalid && s_tready;

    // Clamp the grid shape to what the lanes cover.
    assign rows_eff = gwc_pkg::clamp_dim(rows_reg, gwc_pkg::DIM_W'(gwc_pkg::MAX_ROWS));
    assign cols_eff = gwc_pkg::clamp_dim(cols_reg, gwc_pkg::DIM_W'(gwc_pkg::MAX_COLS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg   <= gwc_pkg::DIM_W'(4);
            cols_reg   <= gwc_pkg::DIM_W'(4);
            length_reg <= gwc_pkg::LEN_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                gwc_pkg::REG_ROWS:   rows_reg   <= cfg_data[gwc_pkg::DIM_W-1:0];
                gwc_pkg::REG_COLS:   cols_reg   <= cfg_data[gwc_pkg::DIM_W-1:0];
                gwc_pkg::REG_LENGTH: length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    gwc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cell_fire   (cell_fire),
        .cell_kind   (gwc_pkg::kind_t'(s_tdata[1:0])),
        .rows_eff    (rows_eff),
        .cols_eff    (cols_eff),
        .walk_length (length_reg),
        .job_push    (push),
        .job_data    (push_job)
    );

    gwc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_data  (pop_job)
    );

    gwc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_valid),
        .job_data  (pop_job),
        .job_pop   (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_count (m_tdata)
    );
endmodule
`default_nettype wire
